// ===== rtl/gpio_block_with_pin_interrupts_defines.svh =====
// Assertion macros for the GPIO interrupt block.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef GPIO_BLOCK_WITH_PIN_INTERRUPTS_DEFINES_SVH
`define GPIO_BLOCK_WITH_PIN_INTERRUPTS_DEFINES_SVH

// same-cycle implication
`define GPIOIRQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GPIOIRQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpioirq_pkg.sv =====
// Package for the GPIO interrupt block: transaction modes and address constants.
// No dependencies.
`timescale 1ns / 1ps
package gpioirq_pkg;
   localparam logic [1:0] MODE_READ = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_HOLD = 2'd2;
   localparam logic [1:0] MODE_CHARGER = 2'd3;

   localparam logic [11:0] MASK_BASE = 12'h800;
   localparam logic [2:0] WIN_INPUT = 3'h3;
   localparam logic [2:0] WIN_STAT = 3'h4;
   localparam logic [2:0] WIN_EN = 3'h5;
   localparam logic [2:0] WIN_CLR = 3'h7;
   localparam logic [11:0] CLR_TO_STAT = 12'h030;

   localparam logic [11:0] PORTA_INPUT = 12'h030;
   localparam logic [11:0] PORTA_STAT = 12'h040;
   localparam logic [11:0] PORTA_LEV = 12'h060;
   localparam logic [11:0] PORTL_INPUT = 12'h13c;
   localparam logic [11:0] PORTL_STAT = 12'h14c;
   localparam logic [11:0] PORTL_LEV = 12'h16c;

   localparam logic [31:0] HOLD_PIN = 32'h20;
   localparam logic [31:0] MAIN_PIN = 32'h08;
   localparam logic [31:0] USB_PIN = 32'h10;

   localparam int GROUPS = 3;
   localparam int PORTS = 4;

   typedef logic [31:0] word_type;
endpackage

// ===== rtl/gpioirq_req_if.sv =====
// Request channel interface (valid/ready plus transaction fields).
// Depends on nothing.
`timescale 1ns / 1ps
interface gpioirq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] offset;
   logic [2:0]  size;
   logic [31:0] write_data;
   logic        hold_engaged;
   logic        main_present;
   logic        usb_present;
   modport source(output valid, mode, offset, size, write_data, hold_engaged,
                  main_present, usb_present, input ready);
   modport sink(input valid, mode, offset, size, write_data, hold_engaged,
                main_present, usb_present, output ready);
endinterface

// ===== rtl/gpioirq_rsp_if.sv =====
// Response channel interface (valid/ready plus read data and irq).
// Depends on nothing.
`timescale 1ns / 1ps
interface gpioirq_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq;
   modport source(output valid, read_data, irq, input ready);
   modport sink(input valid, read_data, irq, output ready);
endinterface

// ===== rtl/gpioirq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module gpioirq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/gpio_block_with_pin_interrupts.sv =====
// Each transaction is a read-modify-write of one word through the register RAM; no new request
// is taken until it is done, nor while a pending response has not been taken.
// Reset: synchronous; afterwards the RAM is cleared one word per cycle,
// all REG_BYTES/4 words; no request is taken until the clear is done.
// Status/enable words of groups 0..2 are shadowed in flops to form irq.
// Depends on gpioirq_pkg, gpioirq_req_if, gpioirq_rsp_if, gpioirq_ram.
`timescale 1ns / 1ps
module gpio_block_with_pin_interrupts #(
   parameter int REG_BYTES = 4096
) (
   input logic            clock,
   input logic            reset,
   gpioirq_req_if.sink    req_ch,
   gpioirq_rsp_if.source  rsp_ch
);
   import gpioirq_pkg::*;
   `include "gpio_block_with_pin_interrupts_defines.svh"

   localparam int DEPTH = REG_BYTES / 4;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic              state_ff, state_in;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [1:0]        mode_ff;
   logic [11:0]       offset_ff;
   logic [2:0]        size_ff;
   logic [31:0]       data_ff;
   logic              hold_new_ff, main_new_ff, usb_new_ff;
   logic              hold_ff, main_ff, usb_ff;
   word_type          stat_sh_ff [GROUPS][PORTS];
   word_type          en_sh_ff [GROUPS][PORTS];
   word_type          stat_sh_in [GROUPS][PORTS];
   word_type          en_sh_in [GROUPS][PORTS];
   logic              rsp_valid_ff;
   word_type          rsp_data_ff, rsp_data_in;
   logic              rsp_irq_ff, irq_in;

   logic              req_fire, finish;
   logic [11:0]       rd_byte;
   logic              ram_wr_en, item_wr;
   logic [11:0]       wr_byte;
   logic [ADDR_W-1:0] ram_wr_addr;
   word_type          ram_wr_data, wr_val, ram_q;

   function automatic logic [11:0] wr_target(input logic [11:0] off);
      logic [11:0] t;
      t = (off >= MASK_BASE) ? off - MASK_BASE : off;
      return {t[11:2], 2'b00};
   endfunction

   function automatic word_type pin_word(input logic [11:0] al, input logic h,
                                         input logic m, input logic u);
      word_type v;
      v = '1;
      if (al == PORTA_INPUT && h) v = v & ~HOLD_PIN;
      if (al == PORTL_INPUT) begin
         if (m) v = v & ~MAIN_PIN;
         if (!u) v = v & ~USB_PIN;
      end
      return v;
   endfunction

   function automatic word_type size_mask(input logic [2:0] sz);
      word_type m;
      case (sz)
         3'd1: m = 32'h0000_00ff;
         3'd2: m = 32'h0000_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE) && !clr_busy_ff &&
                         (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign finish = (state_ff == ST_BUSY);

   // read address for the accepted transaction
   always_comb begin
      logic [11:0] t;
      t = wr_target(req_ch.offset);
      case (req_ch.mode)
         MODE_READ: rd_byte = req_ch.offset;
         MODE_WRITE: rd_byte = (t[6:4] == WIN_CLR) ? t - CLR_TO_STAT : t;
         MODE_HOLD: rd_byte = PORTA_LEV;
         default: rd_byte = PORTL_LEV;
      endcase
   end

   gpioirq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ADDR_W'(rd_byte[11:2])),
      .rd_data (ram_q)
   );

   // modify stage
   always_comb begin
      logic [11:0] al, ral;
      logic [4:0]  sh, rsh;
      logic        in_range, masked;
      word_type    m, bits, pin_old, pin_new, v;
      in_range = 32'(offset_ff) < 32'(REG_BYTES);
      masked = offset_ff >= MASK_BASE;
      al = wr_target(offset_ff);
      sh = {(masked ? offset_ff[1:0] : offset_ff[1:0]), 3'b000};
      m = masked ? (32'(data_ff[15:8]) << sh) : (size_mask(size_ff) << sh);
      bits = masked ? (32'(data_ff[7:0]) << sh) : ((data_ff & size_mask(size_ff)) << sh);
      ral = {offset_ff[11:2], 2'b00};
      rsh = {offset_ff[1:0], 3'b000};
      item_wr = 1'b0;
      wr_byte = al;
      wr_val = ram_q;
      rsp_data_in = '0;
      case (mode_ff)
         MODE_READ: begin
            v = (ral[6:4] == WIN_INPUT) ? pin_word(ral, hold_ff, main_ff, usb_ff) : ram_q;
            if (in_range) rsp_data_in = (v >> rsh) & size_mask(size_ff);
         end
         MODE_WRITE: begin
            item_wr = in_range && al[6:4] != WIN_INPUT && al[6:4] != WIN_STAT;
            if (al[6:4] == WIN_CLR) begin
               wr_byte = al - CLR_TO_STAT;
               wr_val = ram_q & ~(bits & m);
            end else begin
               wr_val = (ram_q & ~m) | (bits & m);
            end
         end
         MODE_HOLD: begin
            item_wr = hold_new_ff != hold_ff;
            pin_old = pin_word(PORTA_INPUT, hold_ff, main_ff, usb_ff);
            pin_new = pin_word(PORTA_INPUT, hold_new_ff, main_ff, usb_ff);
            wr_byte = PORTA_STAT;
            wr_val = stat_sh_ff[0][0] | ((pin_old ^ pin_new) & ~(pin_new ^ ram_q));
         end
         default: begin
            item_wr = main_new_ff != main_ff || usb_new_ff != usb_ff;
            pin_old = pin_word(PORTL_INPUT, hold_ff, main_ff, usb_ff);
            pin_new = pin_word(PORTL_INPUT, hold_ff, main_new_ff, usb_new_ff);
            wr_byte = PORTL_STAT;
            wr_val = stat_sh_ff[2][3] | ((pin_old ^ pin_new) & ~(pin_new ^ ram_q));
         end
      endcase
   end

   assign ram_wr_en = clr_busy_ff || (finish && item_wr);
   assign ram_wr_addr = clr_busy_ff ? clr_cnt_ff : ADDR_W'(wr_byte[11:2]);
   assign ram_wr_data = clr_busy_ff ? '0 : wr_val;

   // shadow of status/enable words, groups 0..2
   always_comb begin
      logic hit;
      hit = finish && item_wr && wr_byte[11:9] == 3'b000 && wr_byte[8:7] != 2'b11;
      irq_in = 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int p = 0; p < PORTS; p++) begin
            stat_sh_in[g][p] = stat_sh_ff[g][p];
            en_sh_in[g][p] = en_sh_ff[g][p];
            if (hit && wr_byte[8:7] == 2'(g) && wr_byte[3:2] == 2'(p)) begin
               if (wr_byte[6:4] == WIN_STAT) stat_sh_in[g][p] = wr_val;
               if (wr_byte[6:4] == WIN_EN) en_sh_in[g][p] = wr_val;
            end
            irq_in = irq_in | (|(stat_sh_in[g][p] & en_sh_in[g][p]));
         end
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_fire ? ST_BUSY : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff <= '0;
         hold_ff <= 1'b0;
         main_ff <= 1'b0;
         usb_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GROUPS; g++) begin
            for (int p = 0; p < PORTS; p++) begin
               stat_sh_ff[g][p] <= '0;
               en_sh_ff[g][p] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) clr_busy_ff <= 1'b0;
         end
         stat_sh_ff <= stat_sh_in;
         en_sh_ff <= en_sh_in;
         if (finish && mode_ff == MODE_HOLD) hold_ff <= hold_new_ff;
         if (finish && mode_ff == MODE_CHARGER) begin
            main_ff <= main_new_ff;
            usb_ff <= usb_new_ff;
         end
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff <= req_ch.mode;
         offset_ff <= req_ch.offset;
         size_ff <= req_ch.size;
         data_ff <= req_ch.write_data;
         hold_new_ff <= req_ch.hold_engaged;
         main_new_ff <= req_ch.main_present;
         usb_new_ff <= req_ch.usb_present;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff <= irq_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;
   assign rsp_ch.irq = rsp_irq_ff;

   `GPIOIRQ_ASSERT_NOW(a_no_req_while_clearing, clr_busy_ff, !req_ch.ready, "ready in clear")
   `GPIOIRQ_ASSERT_NEXT(a_fire_then_busy, req_fire, state_ff == ST_BUSY, "accept did not start RMW")
   `GPIOIRQ_ASSERT_NEXT(a_busy_then_rsp, finish, rsp_valid_ff, "finished transaction lost")
   `GPIOIRQ_ASSERT_NOW(a_wr_only_busy, ram_wr_en, clr_busy_ff || finish, "RAM write outside RMW")
endmodule
